FILE: sv/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types, token codes and character helpers for the token scanner.
// ----------------------------------------------------------------------------
package tks_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_INT   = 2'd2,
        MODE_FRAC  = 2'd3
    } scan_mode_t;

    localparam logic [4:0] KIND_EOF       = 5'd0;
    localparam logic [4:0] KIND_FUN       = 5'd1;
    localparam logic [4:0] KIND_VAR       = 5'd2;
    localparam logic [4:0] KIND_RETURN    = 5'd3;
    localparam logic [4:0] KIND_IDENT     = 5'd4;
    localparam logic [4:0] KIND_NUMBER    = 5'd5;
    localparam logic [4:0] KIND_ASSIGN    = 5'd6;
    localparam logic [4:0] KIND_LPAREN    = 5'd7;
    localparam logic [4:0] KIND_RPAREN    = 5'd8;
    localparam logic [4:0] KIND_LBRACE    = 5'd9;
    localparam logic [4:0] KIND_RBRACE    = 5'd10;
    localparam logic [4:0] KIND_SEMICOLON = 5'd11;
    localparam logic [4:0] KIND_ADD       = 5'd12;
    localparam logic [4:0] KIND_SUB       = 5'd13;
    localparam logic [4:0] KIND_MUL       = 5'd14;
    localparam logic [4:0] KIND_DIV       = 5'd15;
    localparam logic [4:0] KIND_UNKNOWN   = 5'd16;

    localparam logic [7:0] BYTE_END = 8'h00;
    localparam logic [7:0] BYTE_DOT = 8'h2E;

    localparam logic [2:0] ALIVE_ALL  = 3'b111;
    localparam int         KW_FUN     = 0;
    localparam int         KW_VAR     = 1;
    localparam int         KW_RETURN  = 2;
    localparam logic [2:0] KW_IDX_OUT = 3'd7;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [7:0]  length;
        logic [7:0]  bad_byte;
        logic        last;
    } token_t;

    typedef struct packed {
        logic   first_valid;
        logic   second_valid;
        token_t first;
        token_t second;
    } token_pair_t;

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [7:0] fun_char(logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "f";
            3'd1:    c = "u";
            3'd2:    c = "n";
            default: c = BYTE_END;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] var_char(logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "v";
            3'd1:    c = "a";
            3'd2:    c = "r";
            default: c = BYTE_END;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] return_char(logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "r";
            3'd1:    c = "e";
            3'd2:    c = "t";
            3'd3:    c = "u";
            3'd4:    c = "r";
            3'd5:    c = "n";
            default: c = BYTE_END;
        endcase
        return c;
    endfunction

    // idx beyond every keyword maps to a zero char, which no letter matches
    function automatic logic [2:0] alive_next(logic [2:0] alive, logic [2:0] idx,
                                              logic [7:0] b);
        logic [2:0] a;
        a = alive;
        if (fun_char(idx) != b)
            a[KW_FUN] = 1'b0;
        if (var_char(idx) != b)
            a[KW_VAR] = 1'b0;
        if (return_char(idx) != b)
            a[KW_RETURN] = 1'b0;
        return a;
    endfunction

    function automatic logic [4:0] op_kind(logic [7:0] b);
        logic [4:0] k;
        case (b)
            "=":     k = KIND_ASSIGN;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ";":     k = KIND_SEMICOLON;
            "+":     k = KIND_ADD;
            "-":     k = KIND_SUB;
            "*":     k = KIND_MUL;
            "/":     k = KIND_DIV;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

FILE: sv/token_scanner_core.sv
// ----------------------------------------------------------------------------
// token_scanner_core
// Byte-serial lexer: one source byte in, identifier, keyword, number,
// operator, unknown and end-of-source tokens out.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle while tokens are taken. A byte passes a byte
// register, is scanned when the result register has room, and its tokens sit
// in a two-slot result register. A byte yields zero, one or two tokens; the
// token port moves at most one token per cycle, so a byte that both ends a
// pending identifier or number and gives a token of its own holds the result
// register until its first token is taken; otherwise the sustained rate is
// one byte per cycle. Lengths saturate at 2**LENGTH_BITS-1, offsets wrap at
// 2**POSITION_BITS, and a zero byte ends the source and restarts offsets at 0.
module token_scanner_core #(
    parameter int POSITION_BITS = 16,
    parameter int LENGTH_BITS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  in_byte,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [4:0]  token_kind,
    output logic [15:0] token_start,
    output logic [7:0]  token_length,
    output logic [7:0]  token_byte,
    output logic        run_last
);
    import tks_pkg::*;

    logic        held_reg;
    logic [7:0]  byte_reg;
    logic        can_load, step;
    token_pair_t pair;
    token_t      head;

    assign step       = held_reg && can_load;
    assign byte_ready = !held_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= 1'b0;
        else if (byte_ready)
            held_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            byte_reg <= in_byte;
    end

    tks_lexer #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .step_byte (byte_reg),
        .tokens    (pair)
    );

    tks_result_stage u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step),
        .pair        (pair),
        .can_load    (can_load),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .head        (head)
    );

    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign token_byte   = head.bad_byte;
    assign run_last     = head.last;

endmodule

FILE: sv/tks_lexer.sv
// ----------------------------------------------------------------------------
// tks_lexer
// Scan state and per-byte token logic: yields up to two tokens per byte.
// ----------------------------------------------------------------------------
module tks_lexer #(
    parameter int POSITION_BITS = 16,
    parameter int LENGTH_BITS   = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          step_byte,
    output tks_pkg::token_pair_t tokens
);
    import tks_pkg::*;

    localparam int SW = (POSITION_BITS > 16) ? POSITION_BITS : 16;
    localparam int LW = (LENGTH_BITS > 8) ? LENGTH_BITS : 8;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    scan_mode_t               mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic [2:0]               alive_reg, alive_next_v;

    logic                     alpha, digit, cont, flush;
    logic [2:0]               kw_idx;
    logic [4:0]               flush_kind;
    logic [SW-1:0]            pend_start_w, pos_w;
    logic [LW-1:0]            pend_len_w;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [LENGTH_BITS-1:0]   len_ext;
    token_t                   flush_tok, own_tok;
    logic                     own_valid;

    assign alpha   = is_alpha(step_byte);
    assign digit   = is_digit(step_byte);
    assign pos_inc = pos_reg + POSITION_BITS'(1);
    assign len_ext = (len_reg < LEN_MAX) ? len_reg + LENGTH_BITS'(1) : len_reg;
    assign kw_idx  = (len_reg < LENGTH_BITS'(6)) ? len_reg[2:0] : KW_IDX_OUT;

    always_comb
    begin
        case (mode_reg)
            MODE_IDENT: cont = alpha || digit;
            MODE_INT:   cont = digit || (step_byte == BYTE_DOT);
            MODE_FRAC:  cont = digit;
            default:    cont = 1'b0;
        endcase
    end

    assign flush = (mode_reg != MODE_IDLE) && !cont;

    always_comb
    begin
        flush_kind = KIND_NUMBER;
        if (mode_reg == MODE_IDENT)
        begin
            if (len_reg == LENGTH_BITS'(3) && alive_reg[KW_FUN])
                flush_kind = KIND_FUN;
            else if (len_reg == LENGTH_BITS'(3) && alive_reg[KW_VAR])
                flush_kind = KIND_VAR;
            else if (len_reg == LENGTH_BITS'(6) && alive_reg[KW_RETURN])
                flush_kind = KIND_RETURN;
            else
                flush_kind = KIND_IDENT;
        end
    end

    assign pend_start_w = SW'(start_reg);
    assign pend_len_w   = LW'(len_reg);
    assign pos_w        = SW'(pos_reg);

    always_comb
    begin
        flush_tok.kind     = flush_kind;
        flush_tok.start    = pend_start_w[15:0];
        flush_tok.length   = pend_len_w[7:0];
        flush_tok.bad_byte = 8'd0;
        flush_tok.last     = 1'b0;

        own_tok.kind     = op_kind(step_byte);
        own_tok.start    = pos_w[15:0];
        own_tok.length   = 8'd0;
        own_tok.bad_byte = 8'd0;
        own_tok.last     = 1'b1;
        own_valid        = 1'b0;
        if (!cont)
        begin
            if (step_byte == BYTE_END)
            begin
                own_tok.kind = KIND_EOF;
                own_valid    = 1'b1;
            end
            else if (!(alpha || digit))
            begin
                own_valid = 1'b1;
                if (own_tok.kind == KIND_UNKNOWN)
                begin
                    own_tok.length   = 8'd1;
                    own_tok.bad_byte = step_byte;
                end
            end
        end
        flush_tok.last = !own_valid;
    end

    always_comb
    begin
        tokens.first_valid  = flush || own_valid;
        tokens.second_valid = flush && own_valid;
        tokens.first        = flush ? flush_tok : own_tok;
        tokens.second       = own_tok;
    end

    always_comb
    begin
        mode_next    = mode_reg;
        pos_next     = pos_inc;
        start_next   = start_reg;
        len_next     = len_reg;
        alive_next_v = alive_reg;
        if (cont)
        begin
            len_next = len_ext;
            if (mode_reg == MODE_IDENT)
                alive_next_v = alive_next(alive_reg, kw_idx, step_byte);
            if (mode_reg == MODE_INT && step_byte == BYTE_DOT)
                mode_next = MODE_FRAC;
        end
        else if (alpha || digit)
        begin
            start_next   = pos_reg;
            len_next     = LENGTH_BITS'(1);
            alive_next_v = alpha ? alive_next(ALIVE_ALL, 3'd0, step_byte) : ALIVE_ALL;
            mode_next    = alpha ? MODE_IDENT : MODE_INT;
        end
        else
        begin
            mode_next    = MODE_IDLE;
            len_next     = '0;
            alive_next_v = ALIVE_ALL;
            if (step_byte == BYTE_END)
                pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            alive_reg <= ALIVE_ALL;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            alive_reg <= alive_next_v;
        end
    end

endmodule

FILE: sv/tks_result_stage.sv
// ----------------------------------------------------------------------------
// tks_result_stage
// Two-slot result register that hands tokens to the output one per transfer.
// ----------------------------------------------------------------------------
module tks_result_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  tks_pkg::token_pair_t pair,
    output logic                can_load,
    output logic                token_valid,
    input  logic                token_ready,
    output tks_pkg::token_t     head
);
    import tks_pkg::*;

    logic   v0_reg, v0_next, v1_reg, v1_next;
    token_t t0_reg, t1_reg;
    logic   pop;

    assign token_valid = v0_reg || v1_reg;
    assign pop         = token_valid && token_ready;
    assign can_load    = !token_valid || (token_ready && !(v0_reg && v1_reg));
    assign head        = v0_reg ? t0_reg : t1_reg;

    always_comb
    begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        if (pop)
        begin
            if (v0_reg)
                v0_next = 1'b0;
            else
                v1_next = 1'b0;
        end
        if (load)
        begin
            v0_next = pair.first_valid;
            v1_next = pair.second_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            t0_reg <= pair.first;
            t1_reg <= pair.second;
        end
    end

endmodule
